// ===== rtl/ggl_pkg.sv =====
// ggl_pkg: shared widths, reset values, codes and transaction types
// for the gray_gamma_lut block. No dependencies.
package ggl_pkg;

  localparam int GGL_TABLE_DEPTH = 256;
  localparam int GGL_QUEUE_DEPTH = 4;

  localparam int PIX_W      = 8;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int PROD_W     = WEIGHT_W + PIX_W;      // one weighted component
  localparam int NUM_W      = PROD_W + 2;            // sum of three products
  localparam int DEN_W      = WEIGHT_W + 2;          // sum of three weights
  localparam int QUOT_W     = PIX_W;                 // mean of 8-bit values
  localparam int S_DATA_W   = 5 * PIX_W;             // red, green, blue, index, value
  localparam int M_DATA_W   = PIX_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 16'd1225;
  localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 16'd2404;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 16'd467;

  typedef enum logic {
    OP_CONVERT     = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WEIGHT_RED   = 2'd0,
    REG_WEIGHT_GREEN = 2'd1,
    REG_WEIGHT_BLUE  = 2'd2
  } cfg_reg_t;

  // One classified transaction as it sits in the queue.
  typedef struct packed {
    op_t               op;
    logic              last;
    logic [NUM_W-1:0]  num;
    logic [PIX_W-1:0]  tidx;
    logic [PIX_W-1:0]  tval;
  } work_t;

  typedef struct packed {
    logic valid;
    logic push;
  } front_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic pop;
    logic tbl_write;
  } back_status_t;

endpackage

// ===== rtl/ggl_ram.sv =====
// ggl_ram: generic single-port-write, single-port-read RAM with
// registered read data. No dependencies.
module ggl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ggl_front.sv =====
// ggl_front: accepts input transactions, forms the three weighted
// products and hands a classified entry to the queue. Uses ggl_pkg.
module ggl_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ggl_pkg::op_t                      in_op,
  input  logic                              in_last,
  input  logic [ggl_pkg::PIX_W-1:0]         in_red,
  input  logic [ggl_pkg::PIX_W-1:0]         in_green,
  input  logic [ggl_pkg::PIX_W-1:0]         in_blue,
  input  logic [ggl_pkg::PIX_W-1:0]         in_tidx,
  input  logic [ggl_pkg::PIX_W-1:0]         in_tval,
  input  logic [ggl_pkg::WEIGHT_W-1:0]      weight_red,
  input  logic [ggl_pkg::WEIGHT_W-1:0]      weight_green,
  input  logic [ggl_pkg::WEIGHT_W-1:0]      weight_blue,
  input  ggl_pkg::q_status_t                q_status,
  output ggl_pkg::work_t                    entry,
  output ggl_pkg::front_status_t            status
);
  import ggl_pkg::*;

  logic              valid;
  op_t               op;
  logic              last;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;
  logic [PIX_W-1:0]  tidx;
  logic [PIX_W-1:0]  tval;
  logic              push;
  logic              take;

  assign push     = valid && !q_status.full;
  assign in_ready = !valid || !q_status.full;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op     <= in_op;
      last   <= in_last;
      prod_r <= PROD_W'(weight_red) * PROD_W'(in_red);
      prod_g <= PROD_W'(weight_green) * PROD_W'(in_green);
      prod_b <= PROD_W'(weight_blue) * PROD_W'(in_blue);
      tidx   <= in_tidx;
      tval   <= in_tval;
    end
  end

  always_comb begin
    entry.op   = op;
    entry.last = last;
    entry.num  = NUM_W'(prod_r) + NUM_W'(prod_g) + NUM_W'(prod_b);
    entry.tidx = tidx;
    entry.tval = tval;
  end

  assign status.valid = valid;
  assign status.push  = push;

endmodule

// ===== rtl/ggl_queue.sv =====
// ggl_queue: short register FIFO between front and back.
// Uses ggl_pkg.
module ggl_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ggl_pkg::work_t        push_entry,
  input  logic                  pop,
  output ggl_pkg::work_t        head,
  output ggl_pkg::q_status_t    status
);
  import ggl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/ggl_back.sv =====
// ggl_back: pipelined restoring divider (one quotient bit per stage),
// gamma table lookup/write and output register. Uses ggl_pkg, ggl_ram.
module ggl_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ggl_pkg::work_t                 head,
  input  ggl_pkg::q_status_t             q_status,
  input  logic [ggl_pkg::DEN_W-1:0]      den,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ggl_pkg::M_DATA_W-1:0]   out_data,
  output logic                           out_last,
  output ggl_pkg::back_status_t          status
);
  import ggl_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  typedef struct packed {
    op_t               op;
    logic              last;
    logic [NUM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
    logic [PIX_W-1:0]  tidx;
    logic [PIX_W-1:0]  tval;
  } div_t;

  div_t              st    [QUOT_W];
  div_t              st_in [QUOT_W];
  logic [QUOT_W-1:0] st_valid;
  logic              adv;
  logic              pop;
  logic              den_zero;
  div_t              tail;
  logic              tail_valid;
  logic              tbl_write;
  logic [ADDR_W-1:0] raddr;

  assign adv      = !out_valid || out_ready;
  assign pop      = adv && !q_status.empty;
  assign den_zero = (den == '0);

  always_comb begin
    st_in[0].op   = head.op;
    st_in[0].last = head.last;
    st_in[0].rem  = head.num;
    st_in[0].quot = '0;
    st_in[0].tidx = head.tidx;
    st_in[0].tval = head.tval;
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    localparam int SH = QUOT_W - 1 - k;
    logic [NUM_W-1:0] dsh;
    div_t             nxt;

    if (k > 0) begin : g_link
      assign st_in[k] = st[k-1];
    end

    assign dsh = NUM_W'(den) << SH;

    always_comb begin
      nxt = st_in[k];
      if (st_in[k].rem >= dsh) begin
        nxt.rem      = st_in[k].rem - dsh;
        nxt.quot[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (adv) begin
      st_valid <= {st_valid[QUOT_W-2:0], pop};
    end
  end

  assign tail       = st[QUOT_W-1];
  assign tail_valid = st_valid[QUOT_W-1];
  assign tbl_write  = adv && tail_valid && (tail.op == OP_TABLE_WRITE);
  // all-zero weights: the table index is forced to 0
  assign raddr      = den_zero ? '0 : ADDR_W'(tail.quot);

  ggl_ram #(
    .WIDTH (M_DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_write),
    .waddr (ADDR_W'(tail.tidx)),
    .wdata (tail.tval),
    .re    (adv),
    .raddr (raddr),
    .rdata (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tail_valid && (tail.op == OP_CONVERT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last <= tail.last;
    end
  end

  assign status.pop       = pop;
  assign status.tbl_write = tbl_write;

endmodule

// ===== rtl/gray_gamma_lut.sv =====
// gray_gamma_lut: top level. RGB to gray (weighted mean) followed by a
// gamma table. Uses ggl_pkg, ggl_front, ggl_queue, ggl_back.
//
//  channel  | dir | handshake         | contents
//  ---------+-----+-------------------+---------------------------------------
//  s_axis   | in  | tvalid/tready     | pixel or table-write transaction
//  m_axis   | out | tvalid/tready     | corrected gray byte + frame end
//  cfg      | in  | cfg_we            | weight registers 0..2
//
//  One transaction per clock sustained in both directions while m_axis does not stall.
//  From s_axis acceptance to m_axis tvalid an item passes the front product
//  register, the queue and the eight divider stages; the registered table
//  read shares the edge that raises tvalid.
//  Table writes take the same path and give no m_axis transaction.
//  Reset (rst, synchronous) loads the default weights and empties all
//  pipelines; table contents are not touched.
//  A stall on m_axis freezes the back end; the front keeps accepting until
//  the queue fills.
module gray_gamma_lut #(
  parameter int QUEUE_DEPTH = ggl_pkg::GGL_QUEUE_DEPTH,
  parameter int TABLE_DEPTH = ggl_pkg::GGL_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: red[7:0], green[15:8], blue[23:16], table_index[31:24],
  //        table_value[39:32]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ggl_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // tuser: opcode[0]
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              s_axis_tlast,
  // tdata: gray_level[7:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ggl_pkg::M_DATA_W-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [ggl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ggl_pkg::WEIGHT_W-1:0]      cfg_wdata
);
  import ggl_pkg::*;

  logic [WEIGHT_W-1:0] weight_red;
  logic [WEIGHT_W-1:0] weight_green;
  logic [WEIGHT_W-1:0] weight_blue;
  logic [DEN_W-1:0]    den;

  work_t          q_in;
  work_t          q_head;
  front_status_t  front_st;
  q_status_t      q_st;
  back_status_t   back_st;

  // weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_red   <= WEIGHT_RED_RST;
      weight_green <= WEIGHT_GREEN_RST;
      weight_blue  <= WEIGHT_BLUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_WEIGHT_RED:   weight_red   <= cfg_wdata;
        REG_WEIGHT_GREEN: weight_green <= cfg_wdata;
        REG_WEIGHT_BLUE:  weight_blue  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // divisor, registered; weights only change while idle is a rule for the user, not enforced here, so the lag is fine
  always_ff @(posedge clk) begin
    den <= DEN_W'(weight_red) + DEN_W'(weight_green) + DEN_W'(weight_blue);
  end

  ggl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_op        (op_t'(s_axis_tuser[0])),
    .in_last      (s_axis_tlast),
    .in_red       (s_axis_tdata[7:0]),
    .in_green     (s_axis_tdata[15:8]),
    .in_blue      (s_axis_tdata[23:16]),
    .in_tidx      (s_axis_tdata[31:24]),
    .in_tval      (s_axis_tdata[39:32]),
    .weight_red   (weight_red),
    .weight_green (weight_green),
    .weight_blue  (weight_blue),
    .q_status     (q_st),
    .entry        (q_in),
    .status       (front_st)
  );

  ggl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_st.push),
    .push_entry (q_in),
    .pop        (back_st.pop),
    .head       (q_head),
    .status     (q_st)
  );

  ggl_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_status  (q_st),
    .den       (den),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .status    (back_st)
  );

  // a table write never shows up as an output transaction
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    back_st.tbl_write |=> !m_axis_tvalid)
    else $error("table write produced an output transaction");

  // a stalled output must freeze the back end
  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !back_st.pop)
    else $error("queue popped while output stalled");

  // an accepted input transaction is held in the front register
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> front_st.valid)
    else $error("accepted transaction lost in front end");

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    front_st.push |-> !q_st.full)
    else $error("queue overflow");

endmodule
